/* hdl/hkrb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrb_pkg: shared definitions for the HID keyboard report builder
// Sizes, action codes, state encoding, the decoder result type and the
// key code to HID usage translation table.
// ----------------------------------------------------------------------------
package hkrb_pkg;

  // Number of usage slots that a report fills, and the slot ports present.
  localparam int REPORT_SLOTS = 6;
  localparam int SLOT_PORTS   = 6;

  // Number of HID usages tracked in the pressed map.
  localparam int USAGE_RANGE  = 128;
  localparam int USAGE_W      = $clog2(USAGE_RANGE);
  localparam int SCAN_CNT_W   = $clog2(USAGE_RANGE + 1);
  localparam int SLOT_CNT_W   = $clog2(REPORT_SLOTS + 1);

  // Key codes at or above this limit carry no plain usage.
  localparam int CODE_LIMIT   = 128;
  localparam int CODE_W       = 10;

  // Action codes of a key event.
  localparam logic [1:0] ACT_UP     = 2'd0;
  localparam logic [1:0] ACT_DOWN   = 2'd1;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN
  } state_t;

  // Result of translating one key code.
  typedef struct packed {
    logic       known;
    logic       is_mod;
    logic [7:0] mod_mask;
    logic [7:0] usage;
  } decode_t;

  // Linux key code to HID usage; zero means no plain usage.
  localparam logic [7:0] USAGE_TABLE [CODE_LIMIT] = '{
    8'h00, 8'h29, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23,
    8'h24, 8'h25, 8'h26, 8'h27, 8'h2d, 8'h2e, 8'h2a, 8'h2b,
    8'h14, 8'h1a, 8'h08, 8'h15, 8'h17, 8'h1c, 8'h18, 8'h0c,
    8'h12, 8'h13, 8'h2f, 8'h30, 8'h28, 8'h00, 8'h04, 8'h16,
    8'h07, 8'h09, 8'h0a, 8'h0b, 8'h0d, 8'h0e, 8'h0f, 8'h33,
    8'h34, 8'h35, 8'h00, 8'h31, 8'h1d, 8'h1b, 8'h06, 8'h19,
    8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'h00, 8'h55,
    8'h00, 8'h2c, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e,
    8'h3f, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53, 8'h47, 8'h5f,
    8'h60, 8'h61, 8'h56, 8'h5c, 8'h5d, 8'h5e, 8'h57, 8'h59,
    8'h5a, 8'h5b, 8'h62, 8'h63, 8'h00, 8'h00, 8'h64, 8'h44,
    8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h58, 8'h00, 8'h54, 8'h46, 8'h00, 8'h00, 8'h4a, 8'h52,
    8'h4b, 8'h50, 8'h4f, 8'h4d, 8'h51, 8'h4e, 8'h49, 8'h4c,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h48,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h65
  };

endpackage

/* hdl/hkrb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrb_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module hkrb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/hkrb_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrb_decode: key code translation
// Maps a Linux key code to either a modifier bit or a HID usage.
// ----------------------------------------------------------------------------
module hkrb_decode (
  input  logic [hkrb_pkg::CODE_W-1:0] key_code,
  output hkrb_pkg::decode_t           dec
);

  logic [7:0] mask;
  logic [7:0] usage;

  // The eight modifier keys each own one bit of the modifier byte.
  always_comb begin
    case (key_code)
      10'd29:  mask = 8'h01;
      10'd42:  mask = 8'h02;
      10'd56:  mask = 8'h04;
      10'd125: mask = 8'h08;
      10'd97:  mask = 8'h10;
      10'd54:  mask = 8'h20;
      10'd100: mask = 8'h40;
      10'd126: mask = 8'h80;
      default: mask = 8'h00;
    endcase
  end

  // Plain usage lookup for codes below the table limit.
  always_comb begin
    if ({22'd0, key_code} < 32'(hkrb_pkg::CODE_LIMIT)) begin
      usage = hkrb_pkg::USAGE_TABLE[key_code[$clog2(hkrb_pkg::CODE_LIMIT)-1:0]];
    end else begin
      usage = 8'h00;
    end
  end

  // A code is known if it is a modifier or has a nonzero usage.
  always_comb begin
    dec.is_mod   = (mask != 8'h00);
    dec.mod_mask = mask;
    dec.usage    = usage;
    dec.known    = (mask != 8'h00) || (usage != 8'h00);
  end

endmodule

/* hdl/hid_keyboard_report_builder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_top: USB HID boot keyboard report builder
// Tracks modifier and pressed-key state and emits one report per known key
// event.
// ----------------------------------------------------------------------------
// After reset the block clears every entry of the pressed-usage memory, with
// busy high. An event is taken when start is high and busy is low. A
// non-key event or an unknown key code is dropped in the look state that
// follows its capture. A known key event updates the state and then scans the
// pressed-usage memory one entry per cycle through its single read port, so
// its report appears as a one-cycle report_valid beat once the scan is done;
// busy falls in that same cycle. The report fields hold their values until
// the next event is processed. report_valid cannot be held off: the receiver
// must take every beat in the cycle it is shown.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        key_event,
  input  logic [1:0]  action,
  input  logic [9:0]  key_code,
  output logic        report_valid,
  output logic [7:0]  modifiers,
  output logic [7:0]  key_slot_0,
  output logic [7:0]  key_slot_1,
  output logic [7:0]  key_slot_2,
  output logic [7:0]  key_slot_3,
  output logic [7:0]  key_slot_4,
  output logic [7:0]  key_slot_5
);

  localparam int UW = hkrb_pkg::USAGE_W;
  localparam int CW = hkrb_pkg::SCAN_CNT_W;
  localparam int SW = hkrb_pkg::SLOT_CNT_W;

  hkrb_pkg::state_t  state;
  hkrb_pkg::state_t  state_next;
  hkrb_pkg::decode_t dec;

  logic          ev;
  logic [1:0]    act;
  logic [9:0]    code;
  logic [CW-1:0] cnt;
  logic          prev_valid;
  logic [UW-1:0] prev_addr;
  logic [SW-1:0] slot_cnt;
  logic [7:0]    slots [hkrb_pkg::SLOT_PORTS];
  logic [7:0]    mod_reg;

  logic          ram_we;
  logic [UW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_rdata;
  logic          track_write;
  logic          scan_issue;
  logic          scan_done;
  logic          hit;

  // Translation of the latched key code.
  hkrb_decode u_decode (
    .key_code (code),
    .dec      (dec)
  );

  // Pressed-usage bitmap, one bit per usage.
  hkrb_ram #(
    .WIDTH (1),
    .DEPTH (hkrb_pkg::USAGE_RANGE)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[UW-1:0]),
    .rdata (ram_rdata)
  );

  // A key up or down on an in-range usage touches the bitmap.
  assign track_write = !dec.is_mod
                       && ({1'b0, dec.usage} < 9'(hkrb_pkg::USAGE_RANGE))
                       && ((act == hkrb_pkg::ACT_UP) || (act == hkrb_pkg::ACT_DOWN));

  assign scan_issue = (state == hkrb_pkg::ST_SCAN)
                      && (cnt < CW'(hkrb_pkg::USAGE_RANGE));
  assign scan_done  = (state == hkrb_pkg::ST_SCAN)
                      && (cnt == CW'(hkrb_pkg::USAGE_RANGE)) && !prev_valid;
  assign hit        = prev_valid && ram_rdata
                      && (slot_cnt < SW'(hkrb_pkg::REPORT_SLOTS));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hkrb_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory write control.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = dec.usage[UW-1:0];
    ram_wdata  = (act == hkrb_pkg::ACT_DOWN);
    case (state)
      hkrb_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[UW-1:0];
        ram_wdata = 1'b0;
        if (cnt == CW'(hkrb_pkg::USAGE_RANGE - 1)) begin
          state_next = hkrb_pkg::ST_IDLE;
        end
      end
      hkrb_pkg::ST_IDLE: begin
        if (start) begin
          state_next = hkrb_pkg::ST_LOOK;
        end
      end
      hkrb_pkg::ST_LOOK: begin
        if (ev && dec.known) begin
          ram_we     = track_write;
          state_next = hkrb_pkg::ST_SCAN;
        end else begin
          state_next = hkrb_pkg::ST_IDLE;
        end
      end
      hkrb_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = hkrb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hkrb_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != hkrb_pkg::ST_IDLE);

  // Event capture.
  always_ff @(posedge clk) begin
    if ((state == hkrb_pkg::ST_IDLE) && start) begin
      ev   <= key_event;
      act  <= action;
      code <= key_code;
    end
  end

  // Sweep counter for the clearing pass and the scan, plus the read pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      prev_valid <= 1'b0;
    end else begin
      prev_valid <= scan_issue;
      if (state == hkrb_pkg::ST_CLEAR) begin
        cnt <= cnt + CW'(1);
      end else if (state == hkrb_pkg::ST_LOOK) begin
        cnt <= '0;
      end else if (scan_issue) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_addr <= cnt[UW-1:0];
  end

  // Modifier byte: down sets the bit, up clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_reg <= 8'h00;
    end else if ((state == hkrb_pkg::ST_LOOK) && ev && dec.is_mod) begin
      if (act == hkrb_pkg::ACT_UP) begin
        mod_reg <= mod_reg & ~dec.mod_mask;
      end else if (act == hkrb_pkg::ACT_DOWN) begin
        mod_reg <= mod_reg | dec.mod_mask;
      end
    end
  end

  // Slot collection: pressed usages land in ascending order.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_cnt <= '0;
    end else if (state == hkrb_pkg::ST_LOOK) begin
      slot_cnt <= '0;
    end else if (hit) begin
      slot_cnt <= slot_cnt + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < hkrb_pkg::SLOT_PORTS; i++) begin
      if (state == hkrb_pkg::ST_LOOK) begin
        slots[i] <= 8'h00;
      end else if (hit && (32'(slot_cnt) == i)) begin
        slots[i] <= 8'(prev_addr);
      end
    end
  end

  // Report strobe, one beat per finished scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else begin
      report_valid <= scan_done;
    end
  end

  assign modifiers  = mod_reg;
  assign key_slot_0 = slots[0];
  assign key_slot_1 = slots[1];
  assign key_slot_2 = slots[2];
  assign key_slot_3 = slots[3];
  assign key_slot_4 = slots[4];
  assign key_slot_5 = slots[5];

`ifndef SYNTHESIS
  // The report beat lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    report_valid |=> !report_valid)
    else $error("report_valid held for more than one cycle");

  // A report only follows the end of a scan.
  a_strobe_after_scan: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> $past(state) == hkrb_pkg::ST_SCAN)
    else $error("report emitted outside a scan");

  // The bitmap is only written while clearing or updating.
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == hkrb_pkg::ST_CLEAR || state == hkrb_pkg::ST_LOOK))
    else $error("bitmap written outside clear or update");

  // The slot count never exceeds the report size.
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot_cnt <= SW'(hkrb_pkg::REPORT_SLOTS))
    else $error("slot count overflow");

  // No new event is taken while a report is still being built.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == hkrb_pkg::ST_SCAN) |-> busy)
    else $error("ready during scan");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hid_keyboard_report_builder_top
// Key events are sent one beat at a time over the start/busy handshake. An
// internal keyboard-state predictor tracks held modifiers and pressed usages
// and queues the report that each known key event must produce. Every
// report_valid beat is checked field by field against the oldest queued
// report. Directed tests cover ignored events, modifiers and slot overflow;
// random traffic then runs with several levels of sender idling.
// ----------------------------------------------------------------------------
module testbench;

  // Action codes beyond the two that the package names.
  localparam logic [1:0] ACT_REPEAT = 2'd2;
  localparam logic [1:0] ACT_SPARE  = 2'd3;

  // Linux key codes of the eight modifier keys.
  localparam logic [9:0] MOD_CODE_LCTRL  = 10'd29;
  localparam logic [9:0] MOD_CODE_LSHIFT = 10'd42;
  localparam logic [9:0] MOD_CODE_LALT   = 10'd56;
  localparam logic [9:0] MOD_CODE_LGUI   = 10'd125;
  localparam logic [9:0] MOD_CODE_RCTRL  = 10'd97;
  localparam logic [9:0] MOD_CODE_RSHIFT = 10'd54;
  localparam logic [9:0] MOD_CODE_RALT   = 10'd100;
  localparam logic [9:0] MOD_CODE_RGUI   = 10'd126;

  // Highest key code that the bench sends.
  localparam logic [9:0] KEY_CODE_MAX = 10'd767;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 140;
  localparam int STALL_LIMIT    = 2000;
  localparam int MAX_SEND_GAP   = 200;

  // Linux key code to HID usage; zero means the code has no plain usage.
  localparam logic [7:0] HID_USAGE_OF_CODE [128] = '{
    8'h00, 8'h29, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23,
    8'h24, 8'h25, 8'h26, 8'h27, 8'h2d, 8'h2e, 8'h2a, 8'h2b,
    8'h14, 8'h1a, 8'h08, 8'h15, 8'h17, 8'h1c, 8'h18, 8'h0c,
    8'h12, 8'h13, 8'h2f, 8'h30, 8'h28, 8'h00, 8'h04, 8'h16,
    8'h07, 8'h09, 8'h0a, 8'h0b, 8'h0d, 8'h0e, 8'h0f, 8'h33,
    8'h34, 8'h35, 8'h00, 8'h31, 8'h1d, 8'h1b, 8'h06, 8'h19,
    8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'h00, 8'h55,
    8'h00, 8'h2c, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e,
    8'h3f, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53, 8'h47, 8'h5f,
    8'h60, 8'h61, 8'h56, 8'h5c, 8'h5d, 8'h5e, 8'h57, 8'h59,
    8'h5a, 8'h5b, 8'h62, 8'h63, 8'h00, 8'h00, 8'h64, 8'h44,
    8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h58, 8'h00, 8'h54, 8'h46, 8'h00, 8'h00, 8'h4a, 8'h52,
    8'h4b, 8'h50, 8'h4f, 8'h4d, 8'h51, 8'h4e, 8'h49, 8'h4c,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h48,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h65
  };

  // Keys that random traffic hits often, so presses and releases collide.
  localparam int HOT_KEYS = 20;
  localparam logic [9:0] HOT_KEY_CODES [HOT_KEYS] = '{
    MOD_CODE_LCTRL, MOD_CODE_LSHIFT, MOD_CODE_LALT, MOD_CODE_LGUI,
    MOD_CODE_RCTRL, MOD_CODE_RSHIFT, MOD_CODE_RALT, MOD_CODE_RGUI,
    10'd30, 10'd31, 10'd32, 10'd2, 10'd3, 10'd59, 10'd57, 10'd28,
    10'd103, 10'd127, 10'd1, 10'd14
  };

  typedef struct packed {
    logic [7:0]                           mods;
    logic [hkrb_pkg::SLOT_PORTS-1:0][7:0] slots;
  } hid_report_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       key_event = 1'b0;
  logic [1:0] action = hkrb_pkg::ACT_UP;
  logic [9:0] key_code = 10'd0;
  logic       report_valid;
  logic [7:0] modifiers;
  logic [7:0] key_slot_0;
  logic [7:0] key_slot_1;
  logic [7:0] key_slot_2;
  logic [7:0] key_slot_3;
  logic [7:0] key_slot_4;
  logic [7:0] key_slot_5;

  // Predicted keyboard state.
  logic [7:0]  held_mods = 8'h00;
  bit          usage_down [hkrb_pkg::USAGE_RANGE];

  hid_report_t pending_reports [$];
  int          sender_idle_pct = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  hid_keyboard_report_builder_top DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .key_event    (key_event),
    .action       (action),
    .key_code     (key_code),
    .report_valid (report_valid),
    .modifiers    (modifiers),
    .key_slot_0   (key_slot_0),
    .key_slot_1   (key_slot_1),
    .key_slot_2   (key_slot_2),
    .key_slot_3   (key_slot_3),
    .key_slot_4   (key_slot_4),
    .key_slot_5   (key_slot_5)
  );

  always #CLK_HALF clk = ~clk;

  // Modifier mask bit of a key code, zero for ordinary keys.
  function automatic logic [7:0] modifier_mask(input logic [9:0] code);
    case (code)
      MOD_CODE_LCTRL:  return 8'h01;
      MOD_CODE_LSHIFT: return 8'h02;
      MOD_CODE_LALT:   return 8'h04;
      MOD_CODE_LGUI:   return 8'h08;
      MOD_CODE_RCTRL:  return 8'h10;
      MOD_CODE_RSHIFT: return 8'h20;
      MOD_CODE_RALT:   return 8'h40;
      MOD_CODE_RGUI:   return 8'h80;
      default:         return 8'h00;
    endcase
  endfunction

  // Updates the predicted keyboard state for one event and builds the report
  // it should produce. Returns 0 when the event must be dropped silently.
  function automatic bit apply_key_event(input logic kev, input logic [1:0] act,
                                         input logic [9:0] code,
                                         output hid_report_t rpt);
    logic [7:0] mask;
    logic [7:0] usage;
    int         filled;
    int         u;
    mask  = modifier_mask(code);
    usage = 8'h00;
    rpt   = '0;
    if (!kev) return 1'b0;
    if (mask == 8'h00) begin
      if (code >= hkrb_pkg::CODE_LIMIT) return 1'b0;
      usage = HID_USAGE_OF_CODE[code[6:0]];
      if (usage == 8'h00) return 1'b0;
    end
    // Down sets and up clears; repeat and the spare code leave state alone.
    if (mask != 8'h00) begin
      if (act == hkrb_pkg::ACT_UP) held_mods = held_mods & ~mask;
      else if (act == hkrb_pkg::ACT_DOWN) held_mods = held_mods | mask;
    end else if (usage < hkrb_pkg::USAGE_RANGE) begin
      if (act == hkrb_pkg::ACT_UP) usage_down[usage] = 1'b0;
      else if (act == hkrb_pkg::ACT_DOWN) usage_down[usage] = 1'b1;
    end
    // Lowest pressed usages fill the slots in ascending order.
    rpt.mods = held_mods;
    filled = 0;
    for (u = 0; u < hkrb_pkg::USAGE_RANGE; u++) begin
      if (usage_down[u] && filled < hkrb_pkg::REPORT_SLOTS
          && filled < hkrb_pkg::SLOT_PORTS) begin
        rpt.slots[filled] = u[7:0];
        filled++;
      end
    end
    return 1'b1;
  endfunction

  function automatic int pressed_count();
    int n;
    n = 0;
    foreach (usage_down[u]) n += usage_down[u];
    return n;
  endfunction

  // Sends one event beat, after an optional random gap, and records the
  // report it should produce. Start stays high for back-to-back beats.
  task automatic send_key_event(input logic kev, input logic [1:0] act,
                                input logic [9:0] code, output bit reported);
    hid_report_t rpt;
    int          gap;
    gap = 0;
    if ($urandom_range(0, 99) < sender_idle_pct) gap = $urandom_range(1, MAX_SEND_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    key_event <= kev;
    action    <= act;
    key_code  <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
    reported = apply_key_event(kev, act, code, rpt);
    if (reported) pending_reports = {pending_reports, rpt};
  endtask

  task automatic drop_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Non-key events, codes with no usage and codes past the table.
  task automatic test_ignored_events();
    bit r;
    send_key_event(1'b0, ACT_SPARE, KEY_CODE_MAX, r);
    send_key_event(1'b0, hkrb_pkg::ACT_DOWN, 10'd30, r);
    send_key_event(1'b1, hkrb_pkg::ACT_DOWN, 10'd0, r);
    send_key_event(1'b1, hkrb_pkg::ACT_DOWN, 10'd84, r);
    send_key_event(1'b1, hkrb_pkg::ACT_DOWN, 10'd128, r);
    send_key_event(1'b1, hkrb_pkg::ACT_UP, KEY_CODE_MAX, r);
    // Repeat and release of keys that are not held still report.
    send_key_event(1'b1, ACT_REPEAT, 10'd30, r);
    send_key_event(1'b1, hkrb_pkg::ACT_UP, 10'd127, r);
  endtask

  // All eight modifiers down, then repeat, release and the spare action.
  task automatic test_modifier_keys();
    bit r;
    for (int i = 0; i < 8; i++) send_key_event(1'b1, hkrb_pkg::ACT_DOWN, HOT_KEY_CODES[i], r);
    send_key_event(1'b1, ACT_REPEAT, MOD_CODE_RGUI, r);
    send_key_event(1'b1, hkrb_pkg::ACT_UP, MOD_CODE_LCTRL, r);
    send_key_event(1'b1, ACT_SPARE, MOD_CODE_RGUI, r);
  endtask

  // More keys held than slots, pressed out of usage order.
  task automatic test_slot_overflow();
    bit r;
    send_key_event(1'b1, hkrb_pkg::ACT_DOWN, 10'd127, r);
    send_key_event(1'b1, hkrb_pkg::ACT_DOWN, 10'd30, r);
    send_key_event(1'b1, hkrb_pkg::ACT_DOWN, 10'd2, r);
    send_key_event(1'b1, hkrb_pkg::ACT_DOWN, 10'd59, r);
    send_key_event(1'b1, hkrb_pkg::ACT_DOWN, 10'd1, r);
    send_key_event(1'b1, hkrb_pkg::ACT_DOWN, 10'd57, r);
    send_key_event(1'b1, hkrb_pkg::ACT_DOWN, 10'd28, r);
    send_key_event(1'b1, ACT_SPARE, 10'd30, r);
    send_key_event(1'b1, hkrb_pkg::ACT_UP, 10'd30, r);
  endtask

  // Mostly typing on a few hot keys with random content, plus noise.
  task automatic test_random_traffic(input int idle_pct, input int item_count);
    logic       kev;
    logic [1:0] act;
    logic [9:0] code;
    int         pick;
    bit         r;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < item_count; n++) begin
      pick = $urandom_range(0, 99);
      kev  = 1'b1;
      act  = 2'($urandom_range(0, 3));
      if (pick < 8) begin
        kev  = 1'b0;
        code = 10'($urandom_range(0, KEY_CODE_MAX));
      end else if (pick < 16) begin
        code = 10'($urandom_range(0, KEY_CODE_MAX));
      end else begin
        if ($urandom_range(0, 1)) code = HOT_KEY_CODES[$urandom_range(0, HOT_KEYS - 1)];
        else code = 10'($urandom_range(0, hkrb_pkg::CODE_LIMIT - 1));
        pick = $urandom_range(0, 99);
        if (pick < ((pressed_count() < 8) ? 55 : 30)) act = hkrb_pkg::ACT_DOWN;
        else if (pick < 85) act = hkrb_pkg::ACT_UP;
        else if (pick < 95) act = ACT_REPEAT;
        else act = ACT_SPARE;
      end
      send_key_event(kev, act, code, r);
    end
  endtask

  // Each report beat is compared with the oldest predicted report.
  always @(posedge clk) begin
    hid_report_t got;
    hid_report_t want;
    if (!rst && report_valid) begin
      got.mods  = modifiers;
      got.slots = {key_slot_5, key_slot_4, key_slot_3, key_slot_2, key_slot_1, key_slot_0};
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report: modifiers %h slots %h", $time, got.mods,
                 got.slots);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (got.mods !== want.mods) begin
          $display("%0t: modifiers expected %h actual %h", $time, want.mods, got.mods);
          mismatches++;
        end
        for (int s = 0; s < hkrb_pkg::SLOT_PORTS; s++) begin
          if (got.slots[s] !== want.slots[s]) begin
            $display("%0t: key_slot_%0d expected %h actual %h", $time, s,
                     want.slots[s], got.slots[s]);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: too long without an event beat or a report beat ends the run.
  always @(posedge clk) begin
    if ((start && !busy) || report_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("hid_keyboard_report_builder_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_ignored_events();
    test_modifier_keys();
    test_slot_overflow();
    test_random_traffic(0, 190);
    test_random_traffic(72, 190);
    test_random_traffic(29, 190);
    drop_start();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("hid_keyboard_report_builder_top verification clean");
    end else begin
      $display("hid_keyboard_report_builder_top verification failed");
    end
    $finish;
  end

endmodule
